// ===== rtl/etl_pkg.sv =====
// ----------------------------------------------------------------------------
// etl_pkg: escaped text layout package
// Character codes, register indexes, escape states and the colour table.
// ----------------------------------------------------------------------------
package etl_pkg;

   // field widths
   localparam int unsigned CharWidth   = 8;
   localparam int unsigned ColumnWidth = 10;
   localparam int unsigned RowWidth    = 5;
   localparam int unsigned ColorWidth  = 24;
   localparam int unsigned GlyphWWidth = 5;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrWidth    = 24;

   // character codes
   localparam logic [CharWidth-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CharWidth-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_COLOR = 8'h43; // 'C'

   // colour intensities
   localparam logic [7:0] HALF = 8'h7f;
   localparam logic [7:0] FULL = 8'hff;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_START_COLUMN = 3'd0,
      REG_TEXT_ROW     = 3'd1,
      REG_START_COLOR  = 3'd2,
      REG_GLYPH_WIDTH  = 3'd3,
      REG_MEASURE_ONLY = 3'd4
   } csr_index_type;

   // escape state
   typedef enum logic [1:0] {
      ESC_NORMAL    = 2'd0,
      ESC_AFTER_TAB = 2'd1,
      ESC_COLOR     = 2'd2
   } esc_state_type;

   // reset values of the registers
   localparam logic [ColumnWidth-1:0] START_COLUMN_RST = '0;
   localparam logic [RowWidth-1:0]    TEXT_ROW_RST     = '0;
   localparam logic [ColorWidth-1:0]  START_COLOR_RST  = 24'hff0000;
   localparam logic [GlyphWWidth-1:0] GLYPH_WIDTH_RST  = 5'd5;

   // colour picked by the letter after a colour escape
   function automatic logic [ColorWidth-1:0] pick_color(input logic [CharWidth-1:0] c);
      logic [ColorWidth-1:0] rgb;
      begin
         unique case (c)
            8'h67:   rgb = {8'h00, HALF, 8'h00};   // g
            8'h47:   rgb = {8'h00, FULL, 8'h00};   // G
            8'h62:   rgb = {8'h00, 8'h00, HALF};   // b
            8'h42:   rgb = {8'h00, 8'h00, FULL};   // B
            8'h72:   rgb = {HALF, 8'h00, 8'h00};   // r
            8'h52:   rgb = {FULL, 8'h00, 8'h00};   // R
            8'h79:   rgb = {HALF, HALF, 8'h00};    // y
            8'h59:   rgb = {FULL, FULL, 8'h00};    // Y
            8'h77:   rgb = {HALF, HALF, HALF};     // w
            default: rgb = {FULL, FULL, FULL};
         endcase
         return rgb;
      end
   endfunction

endpackage

// ===== rtl/escaped_text_layout.sv =====
// A request is captured in the input register; its result is then offered
// from the result register. One request per cycle while rsp_ready is high;
// the input and result registers each hold one request, so a new request is
// taken while a result waits. Reset (synchronous, active high) clears cursor,
// colour and escape state, loads register defaults and empties both registers.
// ----------------------------------------------------------------------------
// escaped_text_layout: text layout with escape codes for an LED matrix
// Tracks cursor column, colour and escape state; one response per character,
// a draw command only for drawn glyphs, and saturating cursor advance.
// ----------------------------------------------------------------------------
module escaped_text_layout (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic [etl_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [etl_pkg::CsrWidth-1:0]       csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [etl_pkg::CharWidth-1:0]      req_char_code,
   input  logic                               req_first_char,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_draw_valid,
   output logic [etl_pkg::ColumnWidth-1:0]    rsp_draw_column,
   output logic [etl_pkg::RowWidth-1:0]       rsp_draw_row,
   output logic [etl_pkg::ColorWidth-1:0]     rsp_draw_color,
   output logic [etl_pkg::CharWidth-1:0]      rsp_draw_glyph,
   output logic [etl_pkg::ColumnWidth-1:0]    rsp_cursor_after
);
   import etl_pkg::*;

   localparam logic [ColumnWidth-1:0] CursorMax = '1;

   // configuration registers
   logic [ColumnWidth-1:0] start_column_ff;
   logic [RowWidth-1:0]    text_row_ff;
   logic [ColorWidth-1:0]  start_color_ff;
   logic [GlyphWWidth-1:0] glyph_width_ff;
   logic                   measure_only_ff;

   // layout state
   logic [ColumnWidth-1:0] cursor_ff, cursor_in;
   logic [ColorWidth-1:0]  color_ff, color_in;
   esc_state_type          esc_ff, esc_in;

   // input register
   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_char_ff;
   logic                 in_first_ff;

   // result register
   logic                   out_valid_ff;
   logic                   out_draw_ff, out_draw_in;
   logic [ColumnWidth-1:0] out_column_ff, out_column_in;
   logic [RowWidth-1:0]    out_row_ff, out_row_in;
   logic [ColorWidth-1:0]  out_color_ff, out_color_in;
   logic [CharWidth-1:0]   out_glyph_ff, out_glyph_in;
   logic [ColumnWidth-1:0] out_after_ff;

   logic move;

   // handshake: the input register drains into the result register
   assign move      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= START_COLUMN_RST;
         text_row_ff     <= TEXT_ROW_RST;
         start_color_ff  <= START_COLOR_RST;
         glyph_width_ff  <= GLYPH_WIDTH_RST;
         measure_only_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_START_COLUMN: start_column_ff <= csr_wdata[ColumnWidth-1:0];
            REG_TEXT_ROW:     text_row_ff     <= csr_wdata[RowWidth-1:0];
            REG_START_COLOR:  start_color_ff  <= csr_wdata[ColorWidth-1:0];
            REG_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata[GlyphWWidth-1:0];
            REG_MEASURE_ONLY: measure_only_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // layout of the character held in the input register
   always_comb begin
      logic [ColumnWidth-1:0] cur;
      logic [ColorWidth-1:0]  col;
      esc_state_type          esc;
      logic                   draw;
      logic [GlyphWWidth-1:0] step;
      logic [ColumnWidth:0]   sum;

      cur  = in_first_ff ? start_column_ff : cursor_ff;
      col  = in_first_ff ? start_color_ff  : color_ff;
      esc  = in_first_ff ? ESC_NORMAL      : esc_ff;
      draw = 1'b0;
      step = '0;
      esc_in   = ESC_NORMAL;
      color_in = col;

      priority if (in_char_ff == CHAR_TAB) begin
         esc_in = ESC_AFTER_TAB;
      end else if (in_char_ff == CHAR_NUL) begin
         esc_in = ESC_NORMAL;
      end else if (esc == ESC_AFTER_TAB && in_char_ff == CHAR_SPACE) begin
         step = GlyphWWidth'(1);
      end else if (esc == ESC_AFTER_TAB && in_char_ff == CHAR_COLOR) begin
         esc_in = ESC_COLOR;
      end else if (esc == ESC_COLOR) begin
         color_in = pick_color(in_char_ff);
      end else begin
         draw = 1'b1;
         step = glyph_width_ff;
      end

      // saturating advance
      sum       = {1'b0, cur} + {{(ColumnWidth + 1 - GlyphWWidth){1'b0}}, step};
      cursor_in = sum[ColumnWidth] ? CursorMax : sum[ColumnWidth-1:0];

      out_draw_in   = draw && !measure_only_ff;
      out_column_in = out_draw_in ? cur            : '0;
      out_row_in    = out_draw_in ? text_row_ff    : '0;
      out_color_in  = out_draw_in ? col            : '0;
      out_glyph_in  = out_draw_in ? in_char_ff     : '0;
   end

   // state and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         color_ff     <= '0;
         esc_ff       <= ESC_NORMAL;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (move) begin
            cursor_ff    <= cursor_in;
            color_ff     <= color_in;
            esc_ff       <= esc_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_code;
         in_first_ff <= req_first_char;
      end
      if (move) begin
         out_draw_ff   <= out_draw_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         out_color_ff  <= out_color_in;
         out_glyph_ff  <= out_glyph_in;
         out_after_ff  <= cursor_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_draw_valid   = out_draw_ff;
   assign rsp_draw_column  = out_column_ff;
   assign rsp_draw_row     = out_row_ff;
   assign rsp_draw_color   = out_color_ff;
   assign rsp_draw_glyph   = out_glyph_ff;
   assign rsp_cursor_after = out_after_ff;

endmodule
